>>> src/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, operation and status codes, and ring pointer helpers for
// the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Built storage
    localparam int DEPTH  = 16;
    localparam int ELEM_W = 32;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = 5;
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // Item field widths
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Stream packing
    localparam int IN_BITS   = OP_W + ELEM_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STAT_W + CNT_W + 1 + 1 + ELEM_W + ELEM_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ELEM_W-1:0] t_elem;

    // Advance a pointer, wrapping at the capacity in use
    function automatic t_ptr wrap_inc(input t_ptr p, input t_cnt cap);
        t_cnt nxt;
        nxt = t_cnt'(p) + t_cnt'(1);
        wrap_inc = (nxt >= cap) ? '0 : t_ptr'(nxt);
    endfunction

    // Step a pointer back, wrapping at the capacity in use
    function automatic t_ptr wrap_dec(input t_ptr p, input t_cnt cap);
        t_cnt top;
        top = cap - t_cnt'(1);
        wrap_dec = (p == '0) ? t_ptr'(top) : p - t_ptr'(1);
    endfunction

endpackage

>>> src/bounded_deque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Double-ended queue on a ring buffer held in a dual-read synchronous RAM.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless the read stage is stalled. Its
// result passes through the read stage and then the result register before it
// is presented on the result port. The element store is a RAM with one write
// port and two read ports (front and back) whose read data is registered.
// Pointers and count are updated at the accept edge, and a write that lands on
// an entry read at the same edge is forwarded. The result register decouples
// the output, so a new item can still be taken while a result waits, until the
// read stage is also full.
// A write to the capacity register empties the deque; 0 acts as 1 and a value
// above the built depth acts as the depth. Values of an empty deque read 0.
module bounded_deque_unit
    import bdq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // capacity register
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // op, push_value, zero pad
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status, entry_count, is_empty,
                                                  // is_full, front_value,
                                                  // back_value, zero pad
);

    // Field unpack
    logic [OP_W-1:0] w_op;
    t_elem           w_val;
    assign w_op  = s_axis_tdata[OP_W-1:0];
    assign w_val = s_axis_tdata[OP_W +: ELEM_W];

    // Control state
    t_ptr r_front, n_front;
    t_ptr r_back,  n_back;
    t_cnt r_cnt,   n_cnt;
    t_cnt r_cap,   n_cap;

    // Read stage and result register
    logic              r_s1_valid;
    logic [STAT_W-1:0] r_s1_status;
    t_cnt              r_s1_cnt;
    logic              r_s1_full;
    logic              r_s1_fwd_f;
    logic              r_s1_fwd_b;
    t_elem             r_s1_wdata;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Memory
    t_elem r_mem [DEPTH];
    t_elem r_rd_f;
    t_elem r_rd_b;

    logic              w_accept;
    logic              w_advance;
    logic              w_we;
    t_ptr              w_waddr;
    logic [STAT_W-1:0] w_status;
    t_ptr              w_ra_f;
    t_ptr              w_ra_b;
    logic [CMP_W-1:0]  w_cfg_ext;
    logic              w_has_room;
    logic              w_has_item;

    // Handshake: the read stage moves on when the result register is free
    assign w_advance     = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_has_room = (r_cnt < r_cap);
    assign w_has_item = (r_cnt != '0);

    // Operation decode and next pointers
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_cnt    = r_cnt;
        w_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = r_back;
        unique case (w_op)
            OP_PUSH_FRONT: begin
                if (!w_has_room) begin
                    w_status = ST_FULL;
                end else begin
                    n_front = wrap_dec(r_front, r_cap);
                    w_we    = 1'b1;
                    w_waddr = n_front;
                    n_cnt   = r_cnt + t_cnt'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (!w_has_room) begin
                    w_status = ST_FULL;
                end else begin
                    n_back  = wrap_inc(r_back, r_cap);
                    w_we    = 1'b1;
                    w_waddr = r_back;
                    n_cnt   = r_cnt + t_cnt'(1);
                end
            end
            OP_POP_FRONT: begin
                if (!w_has_item) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_front = wrap_inc(r_front, r_cap);
                    n_cnt   = r_cnt - t_cnt'(1);
                end
            end
            OP_POP_BACK: begin
                if (!w_has_item) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_back = wrap_dec(r_back, r_cap);
                    n_cnt  = r_cnt - t_cnt'(1);
                end
            end
            OP_CLEAR: begin
                n_front = '0;
                n_back  = '0;
                n_cnt   = '0;
            end
            default: begin
            end
        endcase
    end

    // Read addresses follow the updated pointers
    assign w_ra_f = n_front;
    assign w_ra_b = wrap_dec(n_back, r_cap);

    // Capacity clamp on write
    assign w_cfg_ext = CMP_W'(i_cfg_wdata);
    always_comb begin
        if (w_cfg_ext == '0) begin
            n_cap = t_cnt'(1);
        end else if (w_cfg_ext > CMP_W'(DEPTH)) begin
            n_cap = t_cnt'(DEPTH);
        end else begin
            n_cap = t_cnt'(w_cfg_ext);
        end
    end

    // Pointer, count and capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_cnt   <= '0;
            r_cap   <= t_cnt'(DEPTH);
        end else if (i_cfg_we) begin
            r_front <= '0;
            r_back  <= '0;
            r_cnt   <= '0;
            r_cap   <= n_cap;
        end else if (w_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_cnt   <= n_cnt;
        end
    end

    // Element store: one write, two registered reads (old data on collision)
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            r_mem[w_waddr] <= w_val;
        end
        if (w_accept) begin
            r_rd_f <= r_mem[w_ra_f];
            r_rd_b <= r_mem[w_ra_b];
        end
    end

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read stage payload, with forwarding of a same-edge write
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_cnt    <= n_cnt;
            r_s1_full   <= (n_cnt == r_cap);
            r_s1_fwd_f  <= w_we && (w_waddr == w_ra_f);
            r_s1_fwd_b  <= w_we && (w_waddr == w_ra_b);
            r_s1_wdata  <= w_val;
        end
    end

    // Result assembly
    t_elem w_front_v;
    t_elem w_back_v;
    logic  w_empty;
    assign w_empty   = (r_s1_cnt == '0);
    assign w_front_v = w_empty ? '0 : (r_s1_fwd_f ? r_s1_wdata : r_rd_f);
    assign w_back_v  = w_empty ? '0 : (r_s1_fwd_b ? r_s1_wdata : r_rd_b);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= OUT_DATA_W'({w_back_v, w_front_v, r_s1_full, w_empty,
                                       r_s1_cnt, r_s1_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> src/bdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the result stream of the bounded deque.
// ----------------------------------------------------------------------------
module bdq_checker
    import bdq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0] w_status;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_empty;
    logic              w_full;
    logic [ELEM_W-1:0] w_front;
    logic [ELEM_W-1:0] w_back;

    assign w_status = m_axis_tdata[STAT_W-1:0];
    assign w_cnt    = m_axis_tdata[STAT_W +: CNT_W];
    assign w_empty  = m_axis_tdata[STAT_W + CNT_W];
    assign w_full   = m_axis_tdata[STAT_W + CNT_W + 1];
    assign w_front  = m_axis_tdata[STAT_W + CNT_W + 2 +: ELEM_W];
    assign w_back   = m_axis_tdata[STAT_W + CNT_W + 2 + ELEM_W +: ELEM_W];

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Empty flag agrees with the count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_empty == (w_cnt == '0)))
        else $error("is_empty disagrees with entry_count");

    // A rejected push leaves a full deque, a rejected pop an empty one
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status != ST_FULL || w_full) &&
                          (w_status != ST_EMPTY || w_empty))
        else $error("reject status without matching flag");

    // An empty deque shows zero values
    a_empty_vals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |-> (w_front == '0) && (w_back == '0))
        else $error("nonzero value from empty deque");

endmodule

bind bounded_deque_unit bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
